@@ hw/rtl/tree_parent_bfs_core_macros.svh @@
// Assertion helpers for the tree_parent_bfs core.
`ifndef TREE_PARENT_BFS_CORE_MACROS_SVH
`define TREE_PARENT_BFS_CORE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define TPB_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define TPB_ASSERT_NEXT(lbl, clk, rst, trig, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/tpb_pkg.sv @@
package tpb_pkg;
   localparam int MAX_NODES  = 1024;
   localparam int EDGE_SLOTS = 2 * MAX_NODES;
   localparam int NODE_W     = 11;                    // node number 0..MAX_NODES
   localparam int NIDX_W     = $clog2(MAX_NODES);     // node index
   localparam int SLOT_W     = $clog2(EDGE_SLOTS);    // edge store index
   localparam int LINK_W     = SLOT_W + 1;            // slot + 1, zero ends a list
   localparam int QPOS_W     = NIDX_W + 1;            // queue position 0..MAX_NODES
   localparam int PAR_W      = NODE_W + 1;            // {seen, parent}

   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_SEARCH = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   localparam logic CSR_NODE_COUNT = 1'b0;
   localparam logic CSR_ROOT_NODE  = 1'b1;
endpackage

@@ hw/rtl/tpb_ram.sv @@
// Simple dual-port RAM: one write port, one registered read port.
module tpb_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 11
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] wa,
   input  logic [WIDTH-1:0]         wd,
   input  logic [$clog2(DEPTH)-1:0] ra,
   output logic [WIDTH-1:0]         rd
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd <= mem[ra];
   end
endmodule

@@ hw/rtl/tree_parent_bfs_core.sv @@
// Breadth-first parent finder over an undirected graph kept as linked adjacency
// lists in on-chip RAM. Each transaction carries an action in req_tuser: add an
// edge (stored on both endpoints' lists), run a search from root_node, read one
// node's parent, or clear the graph. Every transaction returns exactly one
// result (parent in rsp_tdata, reject flag in rsp_tuser). One transaction is
// worked on at a time; the result register lets the next one be taken while a
// result still waits. The sequencer waits on its registered RAM reads: read
// parent reads the parent RAM, add edge appends an entry to each endpoint's
// list, clear graph makes a pass over the list-head RAM, and search makes a
// pass clearing the parent RAM, then walks the list of each visited node.
// After reset a clearing pass over the list-head and parent RAMs runs with
// req_tready low; configuration writes are taken during it.
module tree_parent_bfs_core
   import tpb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,    // end_a[10:0], end_b[21:11], query_node[32:22], 0
   input  logic [1:0]  req_tuser,    // action[1:0]
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // parent_node[10:0], 0
   output logic        rsp_tuser,    // status[0]
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [3:0] ST_INIT  = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_AP0   = 4'd2;
   localparam logic [3:0] ST_AP1   = 4'd3;
   localparam logic [3:0] ST_SWEEP = 4'd4;
   localparam logic [3:0] ST_ROOT  = 4'd5;
   localparam logic [3:0] ST_DEQ   = 4'd6;
   localparam logic [3:0] ST_DEQ1  = 4'd7;
   localparam logic [3:0] ST_HEAD  = 4'd8;
   localparam logic [3:0] ST_LINK  = 4'd9;
   localparam logic [3:0] ST_TGT   = 4'd10;
   localparam logic [3:0] ST_MARK  = 4'd11;
   localparam logic [3:0] ST_RD    = 4'd12;
   localparam logic [3:0] ST_RD1   = 4'd13;
   localparam logic [3:0] ST_DONE  = 4'd14;

   localparam logic [LINK_W-1:0] FILL_MAX = LINK_W'(EDGE_SLOTS);
   localparam logic [NODE_W-1:0] NODE_MAX = NODE_W'(MAX_NODES);
   localparam logic [QPOS_W-1:0] QPOS_MAX = QPOS_W'(MAX_NODES);

   // ---------------------------------------------------------------- registers
   logic [3:0]        state_ff, state_in;
   logic [NODE_W-1:0] count_ff, root_ff;
   logic [NODE_W-1:0] a_ff, a_in, b_ff, b_in, q_ff, q_in;
   logic              phase_ff, phase_in;
   logic              search_ff, search_in;
   logic [NIDX_W-1:0] sweep_ff, sweep_in;
   logic [LINK_W-1:0] fill_ff, fill_in;
   logic [QPOS_W-1:0] qr_ff, qr_in, qw_ff, qw_in;
   logic [NODE_W-1:0] cur_ff, cur_in, nxt_ff, nxt_in;
   logic [LINK_W-1:0] link_ff, link_in;
   logic [NODE_W-1:0] res_par_ff, res_par_in;
   logic              res_st_ff, res_st_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [NODE_W-1:0] rsp_par_ff, rsp_par_in;
   logic              rsp_st_ff, rsp_st_in;

   // ---------------------------------------------------------------- RAM ports
   logic              tgt_we, lnk_we, head_we, tail_we, par_we, que_we;
   logic [SLOT_W-1:0] tgt_wa, tgt_ra, lnk_wa, lnk_ra;
   logic [NODE_W-1:0] tgt_wd, tgt_rd;
   logic [LINK_W-1:0] lnk_wd, lnk_rd;
   logic [NIDX_W-1:0] head_wa, head_ra, tail_wa, tail_ra, par_wa, par_ra, que_wa, que_ra;
   logic [LINK_W-1:0] head_wd, head_rd;
   logic [SLOT_W-1:0] tail_wd, tail_rd;
   logic [PAR_W-1:0]  par_wd, par_rd;
   logic [NODE_W-1:0] que_wd, que_rd;

   // adjacency entries: target node and link to the next entry
   tpb_ram #(.DEPTH(EDGE_SLOTS), .WIDTH(NODE_W)) u_tgt (
      .clock(clock), .we(tgt_we), .wa(tgt_wa), .wd(tgt_wd), .ra(tgt_ra), .rd(tgt_rd));
   tpb_ram #(.DEPTH(EDGE_SLOTS), .WIDTH(LINK_W)) u_lnk (
      .clock(clock), .we(lnk_we), .wa(lnk_wa), .wd(lnk_wd), .ra(lnk_ra), .rd(lnk_rd));
   // per-node list head (slot + 1) and tail (slot)
   tpb_ram #(.DEPTH(MAX_NODES), .WIDTH(LINK_W)) u_head (
      .clock(clock), .we(head_we), .wa(head_wa), .wd(head_wd), .ra(head_ra), .rd(head_rd));
   tpb_ram #(.DEPTH(MAX_NODES), .WIDTH(SLOT_W)) u_tail (
      .clock(clock), .we(tail_we), .wa(tail_wa), .wd(tail_wd), .ra(tail_ra), .rd(tail_rd));
   // per-node {seen, parent}
   tpb_ram #(.DEPTH(MAX_NODES), .WIDTH(PAR_W)) u_par (
      .clock(clock), .we(par_we), .wa(par_wa), .wd(par_wd), .ra(par_ra), .rd(par_rd));
   // search queue
   tpb_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_que (
      .clock(clock), .we(que_we), .wa(que_wa), .wd(que_wd), .ra(que_ra), .rd(que_rd));

   // ---------------------------------------------------------------- helpers
   logic [NODE_W-1:0] eff_count;
   assign eff_count = (count_ff > NODE_MAX) ? NODE_MAX : count_ff;

   function automatic logic node_ok(input logic [NODE_W-1:0] n, input logic [NODE_W-1:0] lim);
      return (n != '0) && (n <= lim);
   endfunction

   function automatic logic [NIDX_W-1:0] nidx(input logic [NODE_W-1:0] n);
      logic [NODE_W-1:0] m;
      m = n - NODE_W'(1);
      return m[NIDX_W-1:0];
   endfunction

   logic [NODE_W-1:0] req_a, req_b, req_q;
   assign req_a = req_tdata[10:0];
   assign req_b = req_tdata[21:11];
   assign req_q = req_tdata[32:22];

   logic              link_ok, tgt_ok;
   logic [LINK_W-1:0] link_m1;
   assign link_ok = (link_ff != '0) && (link_ff <= FILL_MAX);
   assign link_m1 = link_ff - LINK_W'(1);
   assign tgt_ok  = (tgt_rd != '0) && (tgt_rd <= NODE_MAX);

   logic rsp_free;
   assign rsp_free = !rsp_vld_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in   = state_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      q_in       = q_ff;
      phase_in   = phase_ff;
      search_in  = search_ff;
      sweep_in   = sweep_ff;
      fill_in    = fill_ff;
      qr_in      = qr_ff;
      qw_in      = qw_ff;
      cur_in     = cur_ff;
      nxt_in     = nxt_ff;
      link_in    = link_ff;
      res_par_in = res_par_ff;
      res_st_in  = res_st_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_tready;
      rsp_par_in = rsp_par_ff;
      rsp_st_in  = rsp_st_ff;

      tgt_we = 1'b0; tgt_wa = fill_ff[SLOT_W-1:0]; tgt_wd = b_ff; tgt_ra = link_m1[SLOT_W-1:0];
      lnk_we = 1'b0; lnk_wa = fill_ff[SLOT_W-1:0]; lnk_wd = '0;   lnk_ra = link_m1[SLOT_W-1:0];
      head_we = 1'b0; head_wa = nidx(a_ff); head_wd = '0; head_ra = nidx(a_ff);
      tail_we = 1'b0; tail_wa = nidx(a_ff); tail_wd = fill_ff[SLOT_W-1:0]; tail_ra = nidx(a_ff);
      par_we = 1'b0; par_wa = sweep_ff; par_wd = '0; par_ra = nidx(q_ff);
      que_we = 1'b0; que_wa = qw_ff[NIDX_W-1:0]; que_wd = nxt_ff; que_ra = qr_ff[NIDX_W-1:0];

      case (state_ff)
         ST_INIT: begin
            // clear list heads and parents after reset
            head_we  = 1'b1;
            head_wa  = sweep_ff;
            par_we   = 1'b1;
            sweep_in = sweep_ff + NIDX_W'(1);
            if (sweep_ff == NIDX_W'(MAX_NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               a_in       = req_a;
               b_in       = req_b;
               q_in       = req_q;
               phase_in   = 1'b0;
               sweep_in   = '0;
               res_par_in = '0;
               res_st_in  = 1'b0;
               case (req_tuser)
                  ACT_ADD: begin
                     if (!node_ok(req_a, eff_count) || !node_ok(req_b, eff_count)
                         || (fill_ff + LINK_W'(2) > FILL_MAX)) begin
                        res_st_in = 1'b1;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_AP0;
                     end
                  end
                  ACT_SEARCH: begin
                     search_in = 1'b1;
                     state_in  = ST_SWEEP;
                  end
                  ACT_READ: begin
                     if (node_ok(req_q, eff_count)) begin
                        state_in = ST_RD;
                     end else begin
                        res_st_in = 1'b1;
                        state_in  = ST_DONE;
                     end
                  end
                  default: begin
                     // clear graph: drop all edges, sweep the list heads
                     fill_in   = '0;
                     search_in = 1'b0;
                     state_in  = ST_SWEEP;
                  end
               endcase
            end
         end
         ST_AP0: begin
            // store the new entry, fetch head and tail of the owner's list
            tgt_we = 1'b1;
            lnk_we = 1'b1;
            state_in = ST_AP1;
         end
         ST_AP1: begin
            if (head_rd == '0) begin
               head_we = 1'b1;
               head_wd = fill_ff + LINK_W'(1);
            end else begin
               lnk_we = 1'b1;
               lnk_wa = tail_rd;
               lnk_wd = fill_ff + LINK_W'(1);
            end
            tail_we = 1'b1;
            fill_in = fill_ff + LINK_W'(1);
            if (!phase_ff) begin
               // second half: same edge seen from the other endpoint
               a_in     = b_ff;
               b_in     = a_ff;
               phase_in = 1'b1;
               state_in = ST_AP0;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SWEEP: begin
            if (search_ff) begin
               par_we = 1'b1;
            end else begin
               head_we = 1'b1;
               head_wa = sweep_ff;
            end
            sweep_in = sweep_ff + NIDX_W'(1);
            if (sweep_ff == NIDX_W'(MAX_NODES - 1)) begin
               state_in = search_ff ? ST_ROOT : ST_DONE;
            end
         end
         ST_ROOT: begin
            qr_in = '0;
            qw_in = '0;
            if (node_ok(root_ff, eff_count)) begin
               par_we   = 1'b1;
               par_wa   = nidx(root_ff);
               par_wd   = {1'b1, {NODE_W{1'b0}}};
               que_we   = 1'b1;
               que_wa   = '0;
               que_wd   = root_ff;
               qw_in    = QPOS_W'(1);
               state_in = ST_DEQ;
            end else begin
               res_st_in = 1'b1;
               state_in  = ST_DONE;
            end
         end
         ST_DEQ: begin
            if (qr_ff < qw_ff) begin
               qr_in    = qr_ff + QPOS_W'(1);
               state_in = ST_DEQ1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DEQ1: begin
            cur_in   = que_rd;
            head_ra  = nidx(que_rd);
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            link_in  = head_rd;
            state_in = ST_LINK;
         end
         ST_LINK: begin
            // entry address goes out on tgt_ra / lnk_ra
            state_in = link_ok ? ST_TGT : ST_DEQ;
         end
         ST_TGT: begin
            nxt_in  = tgt_rd;
            link_in = lnk_rd;
            par_ra  = nidx(tgt_rd);
            state_in = tgt_ok ? ST_MARK : ST_LINK;
         end
         ST_MARK: begin
            if (!par_rd[NODE_W] && (qw_ff < QPOS_MAX)) begin
               par_we = 1'b1;
               par_wa = nidx(nxt_ff);
               par_wd = {1'b1, cur_ff};
               que_we = 1'b1;
               qw_in  = qw_ff + QPOS_W'(1);
            end
            state_in = ST_LINK;
         end
         ST_RD: begin
            state_in = ST_RD1;
         end
         ST_RD1: begin
            res_par_in = par_rd[NODE_W-1:0];
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // hand the result over once the output register is free
            if (rsp_free) begin
               rsp_vld_in = 1'b1;
               rsp_par_in = res_par_ff;
               rsp_st_in  = res_st_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         sweep_ff   <= '0;
         fill_ff    <= '0;
         qr_ff      <= '0;
         qw_ff      <= '0;
         rsp_vld_ff <= 1'b0;
         search_ff  <= 1'b0;
         phase_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sweep_ff   <= sweep_in;
         fill_ff    <= fill_in;
         qr_ff      <= qr_in;
         qw_ff      <= qw_in;
         rsp_vld_ff <= rsp_vld_in;
         search_ff  <= search_in;
         phase_ff   <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      q_ff       <= q_in;
      cur_ff     <= cur_in;
      nxt_ff     <= nxt_in;
      link_ff    <= link_in;
      res_par_ff <= res_par_in;
      res_st_ff  <= res_st_in;
      rsp_par_ff <= rsp_par_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'b0, rsp_par_ff};
   assign rsp_tuser  = rsp_st_ff;

   // ---------------------------------------------------------------- registers port
   logic csr_wr;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= NODE_W'(2);
         root_ff  <= NODE_W'(1);
      end else if (csr_wr) begin
         if (csr_paddr[2] == CSR_NODE_COUNT) begin
            count_ff <= csr_pwdata[NODE_W-1:0];
         end else begin
            root_ff <= csr_pwdata[NODE_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_ROOT_NODE) ? {21'b0, root_ff} : {21'b0, count_ff};

   // ---------------------------------------------------------------- checks
`include "tree_parent_bfs_core_macros.svh"

   `TPB_ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= FILL_MAX, "edge store overfilled")
   `TPB_ASSERT_ALWAYS(a_queue_order, clock, reset, qr_ff <= qw_ff && qw_ff <= QPOS_MAX, "queue positions crossed")
   `TPB_ASSERT_NEXT(a_busy_after_take, clock, reset, req_tvalid && req_tready, !req_tready, "took a transaction while busy")
   `TPB_ASSERT_NEXT(a_done_delivers, clock, reset, state_ff == ST_DONE && rsp_free, rsp_tvalid, "result lost at hand-over")

endmodule
